### hw/rtl/saff_pkg.sv
`default_nettype none

package saff_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned OffsW   = 8;
  localparam int unsigned CommitW = 9;
  localparam int unsigned FuncW   = 3;
  localparam int unsigned FrameW  = 2 * WordW;

  // Input tdata layout, lowest bit first
  localparam int unsigned InOffsLsb   = 0;
  localparam int unsigned InLeftLsb   = InOffsLsb + OffsW;
  localparam int unsigned InRightLsb  = InLeftLsb + WordW;
  localparam int unsigned InCommitLsb = InRightLsb + WordW;
  localparam int unsigned InRawW      = InCommitLsb + CommitW;
  localparam int unsigned InDataW     = ((InRawW + 7) / 8) * 8;

  typedef enum logic [FuncW-1:0] {
    FN_STAGE  = 3'd0,
    FN_COMMIT = 3'd1,
    FN_PUSH   = 3'd2,
    FN_POP    = 3'd3,
    FN_CLEAR  = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVFL = 2'd1,
    ST_UDFL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    JM_UNKNOWN = 2'd0,
    JM_LEFT    = 2'd1,
    JM_RIGHT   = 2'd2
  } just_e;

  // One frame as held in the store
  typedef struct packed {
    logic [WordW-1:0] right;
    logic [WordW-1:0] left;
  } frame_t;

endpackage

`default_nettype wire

### hw/rtl/saff_mem.sv
`default_nettype none

module saff_mem #(
  parameter int unsigned DEPTH_FRAMES = 1024,
  parameter int unsigned IdxW         = 10
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IdxW-1:0]  waddr_i,
  input  wire saff_pkg::frame_t wdata_i,
  input  wire logic             re_i,
  input  wire logic [IdxW-1:0]  raddr_i,
  output      saff_pkg::frame_t rdata_o
);

  saff_pkg::frame_t mem_q [DEPTH_FRAMES];
  saff_pkg::frame_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/saff_just.sv
`default_nettype none

module saff_just (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          detect_i,
  input  wire saff_pkg::frame_t              frame_i,
  output      logic [saff_pkg::WordW-1:0]    left_o,
  output      logic [saff_pkg::WordW-1:0]    right_o,
  output      saff_pkg::just_e               mode_o
);

  saff_pkg::just_e just_q, just_d;
  logic            low_zero;

  // Low bytes both clear suggests left-justified 24-bit data
  assign low_zero = ((frame_i.left[7:0] | frame_i.right[7:0]) == 8'h00);

  always_comb begin
    just_d = just_q;
    if (detect_i && (just_q == saff_pkg::JM_UNKNOWN)) begin
      just_d = low_zero ? saff_pkg::JM_LEFT : saff_pkg::JM_RIGHT;
    end
  end

  always_comb begin
    if (just_d == saff_pkg::JM_RIGHT) begin
      left_o  = frame_i.left;
      right_o = frame_i.right;
    end else begin
      left_o  = {{8{frame_i.left[saff_pkg::WordW-1]}}, frame_i.left[saff_pkg::WordW-1:8]};
      right_o = {{8{frame_i.right[saff_pkg::WordW-1]}}, frame_i.right[saff_pkg::WordW-1:8]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      just_q <= saff_pkg::JM_UNKNOWN;
    end else begin
      just_q <= just_d;
    end
  end

  assign mode_o = just_d;

endmodule

`default_nettype wire

### hw/rtl/stereo_audio_frame_fifo.sv
`default_nettype none

// Ring buffer of stereo frames (left and right 32-bit words) with one result item per
// input item. Stage, commit, push, clear and a pop from an empty buffer load their result
// directly; a pop with data goes through a read state, as the frame store has a registered
// read port and the popped words come back in the cycle after the read is issued. A new
// item is taken once the previous one is done and the output register is free or being
// drained. Levels count frames. The store is not cleared at reset, so there is no start-up
// sweep: the buffer is ready straight out of reset.
module stereo_audio_frame_fifo #(
  parameter int unsigned DEPTH_FRAMES = 1024,
  localparam int unsigned LvlW       = $clog2(DEPTH_FRAMES + 1),
  localparam int unsigned OutRawW    = 2 * saff_pkg::WordW + 2 + 2 * LvlW + 2,
  localparam int unsigned OutDataW   = ((OutRawW + 7) / 8) * 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  // stage_offset, left_word, right_word, commit_frames
  input  wire logic [saff_pkg::InDataW-1:0]  s_axis_tdata,
  // func
  input  wire logic [saff_pkg::FuncW-1:0]    s_axis_tuser,
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // left_out, right_out, status, level_frames, free_frames, justify_mode
  output      logic [OutDataW-1:0]           m_axis_tdata,
  // ok
  output      logic [0:0]                    m_axis_tuser
);

  localparam int unsigned IdxW = $clog2(DEPTH_FRAMES);
  localparam int unsigned SumW = ((LvlW > saff_pkg::CommitW) ? LvlW : saff_pkg::CommitW) + 1;
  localparam int unsigned WordW = saff_pkg::WordW;

  typedef enum logic {
    S_IDLE,
    S_POP_RD
  } state_e;

  state_e              state_q, state_d;
  logic [IdxW-1:0]     wr_idx_q, wr_idx_d;
  logic [IdxW-1:0]     rd_idx_q, rd_idx_d;
  logic [LvlW-1:0]     level_q, level_d;
  saff_pkg::status_e   status_q, status_d;
  logic                m_valid_q, m_valid_d;
  logic                ok_q, ok_d;
  logic [WordW-1:0]    left_q, left_d;
  logic [WordW-1:0]    right_q, right_d;
  logic [1:0]          stat_out_q, stat_out_d;
  logic [LvlW-1:0]     lvl_out_q, lvl_out_d;
  logic [LvlW-1:0]     free_out_q, free_out_d;
  logic [1:0]          mode_out_q, mode_out_d;

  logic                          accept;
  saff_pkg::func_e               func;
  logic [saff_pkg::OffsW-1:0]    offs;
  logic [WordW-1:0]              lw, rw;
  logic [saff_pkg::CommitW-1:0]  ncommit;

  logic                mem_we, mem_re;
  logic [IdxW-1:0]     mem_waddr;
  saff_pkg::frame_t    mem_wdata, mem_rdata;
  logic [WordW-1:0]    conv_left, conv_right;
  saff_pkg::just_e     mode;

  logic [IdxW-1:0]     offs_mod [256];
  logic [IdxW:0]       stage_sum, commit_wsum;
  logic [IdxW-1:0]     stage_addr, commit_widx, wr_inc, rd_inc;
  logic [SumW-1:0]     commit_lsum;
  logic                res_load;

  assign s_axis_tready = (state_q == S_IDLE) && (!m_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign func    = saff_pkg::func_e'(s_axis_tuser);
  assign offs    = s_axis_tdata[saff_pkg::InOffsLsb +: saff_pkg::OffsW];
  assign lw      = s_axis_tdata[saff_pkg::InLeftLsb +: WordW];
  assign rw      = s_axis_tdata[saff_pkg::InRightLsb +: WordW];
  assign ncommit = s_axis_tdata[saff_pkg::InCommitLsb +: saff_pkg::CommitW];

  // Offset reduced modulo the depth, worked out at elaboration
  for (genvar g = 0; g < 256; g++) begin : g_offs
    localparam int unsigned OffsMod = g % DEPTH_FRAMES;
    assign offs_mod[g] = IdxW'(OffsMod);
  end

  assign stage_sum  = {1'b0, wr_idx_q} + {1'b0, offs_mod[offs]};
  assign stage_addr = (stage_sum >= (IdxW+1)'(DEPTH_FRAMES))
                      ? IdxW'(stage_sum - (IdxW+1)'(DEPTH_FRAMES)) : stage_sum[IdxW-1:0];

  // The level sum decides whether the commit fits; the new write index is only used when it does
  assign commit_lsum = SumW'(level_q) + SumW'(ncommit);
  assign commit_wsum = {1'b0, wr_idx_q} + (IdxW+1)'(ncommit);
  assign commit_widx = (commit_wsum >= (IdxW+1)'(DEPTH_FRAMES))
                       ? IdxW'(commit_wsum - (IdxW+1)'(DEPTH_FRAMES)) : commit_wsum[IdxW-1:0];

  assign wr_inc = (wr_idx_q == IdxW'(DEPTH_FRAMES - 1)) ? '0 : wr_idx_q + 1'b1;
  assign rd_inc = (rd_idx_q == IdxW'(DEPTH_FRAMES - 1)) ? '0 : rd_idx_q + 1'b1;

  always_comb begin
    state_d    = state_q;
    wr_idx_d   = wr_idx_q;
    rd_idx_d   = rd_idx_q;
    level_d    = level_q;
    status_d   = status_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    ok_d       = ok_q;
    left_d     = left_q;
    right_d    = right_q;
    stat_out_d = stat_out_q;
    lvl_out_d  = lvl_out_q;
    free_out_d = free_out_q;
    mode_out_d = mode_out_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = stage_addr;
    mem_wdata  = '{right: rw, left: lw};
    res_load   = 1'b0;
    ok_d       = ok_q;

    if (state_q == S_POP_RD) begin
      state_d  = S_IDLE;
      res_load = 1'b1;
      ok_d     = 1'b1;
      left_d   = conv_left;
      right_d  = conv_right;
    end else if (accept) begin
      res_load = 1'b1;
      ok_d     = 1'b0;
      left_d   = '0;
      right_d  = '0;
      unique case (func)
        saff_pkg::FN_STAGE: begin
          mem_we = 1'b1;
        end
        saff_pkg::FN_COMMIT: begin
          if (ncommit != '0) begin
            if (commit_lsum > SumW'(DEPTH_FRAMES)) begin
              level_d  = LvlW'(DEPTH_FRAMES);
              status_d = saff_pkg::ST_OVFL;
            end else begin
              level_d  = LvlW'(commit_lsum);
              wr_idx_d = commit_widx;
              status_d = saff_pkg::ST_OK;
            end
          end
        end
        saff_pkg::FN_PUSH: begin
          if (level_q == LvlW'(DEPTH_FRAMES)) begin
            status_d = saff_pkg::ST_OVFL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = wr_idx_q;
            mem_wdata = '{right: {rw[WordW-9:0], 8'h00}, left: {lw[WordW-9:0], 8'h00}};
            level_d   = level_q + 1'b1;
            wr_idx_d  = wr_inc;
            status_d  = saff_pkg::ST_OK;
            ok_d      = 1'b1;
          end
        end
        saff_pkg::FN_POP: begin
          if (level_q == '0) begin
            status_d = saff_pkg::ST_UDFL;
          end else begin
            // Result is formed once the store returns the frame
            mem_re   = 1'b1;
            rd_idx_d = rd_inc;
            level_d  = level_q - 1'b1;
            status_d = saff_pkg::ST_OK;
            state_d  = S_POP_RD;
            res_load = 1'b0;
          end
        end
        saff_pkg::FN_CLEAR: begin
          wr_idx_d = '0;
          rd_idx_d = '0;
          level_d  = '0;
          status_d = saff_pkg::ST_OK;
        end
        default: begin
        end
      endcase
    end

    if (res_load) begin
      m_valid_d  = 1'b1;
      stat_out_d = status_d;
      lvl_out_d  = level_d;
      free_out_d = LvlW'(DEPTH_FRAMES) - level_d;
      mode_out_d = mode;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      wr_idx_q   <= '0;
      rd_idx_q   <= '0;
      level_q    <= '0;
      status_q   <= saff_pkg::ST_OK;
      m_valid_q  <= 1'b0;
      ok_q       <= 1'b0;
      left_q     <= '0;
      right_q    <= '0;
      stat_out_q <= '0;
      lvl_out_q  <= '0;
      free_out_q <= '0;
      mode_out_q <= '0;
    end else begin
      state_q    <= state_d;
      wr_idx_q   <= wr_idx_d;
      rd_idx_q   <= rd_idx_d;
      level_q    <= level_d;
      status_q   <= status_d;
      m_valid_q  <= m_valid_d;
      ok_q       <= ok_d;
      left_q     <= left_d;
      right_q    <= right_d;
      stat_out_q <= stat_out_d;
      lvl_out_q  <= lvl_out_d;
      free_out_q <= free_out_d;
      mode_out_q <= mode_out_d;
    end
  end

  saff_mem #(
    .DEPTH_FRAMES(DEPTH_FRAMES),
    .IdxW        (IdxW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(rd_idx_q),
    .rdata_o(mem_rdata)
  );

  saff_just u_just (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .detect_i(state_q == S_POP_RD),
    .frame_i (mem_rdata),
    .left_o  (conv_left),
    .right_o (conv_right),
    .mode_o  (mode)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = ok_q;
  assign m_axis_tdata  = OutDataW'({mode_out_q, free_out_q, lvl_out_q, stat_out_q,
                                    right_q, left_q});

endmodule

`default_nettype wire

### tb/sv/stereo_audio_frame_fifo_test.sv
`timescale 1ns / 100ps

module stereo_audio_frame_fifo_test;
  import saff_pkg::*;

  localparam int unsigned Depth       = 1024;
  localparam int unsigned LvlW        = 11;
  localparam int unsigned OutW        = 96;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomItems = 1250;
  localparam int unsigned CalmItems   = 150;
  localparam int unsigned MaxReports  = 40;
  localparam int unsigned DrainCycles = 10;
  // func codes that the block leaves alone
  localparam logic [FuncW-1:0] FnSpareLo = 3'd5;
  localparam logic [FuncW-1:0] FnSpareHi = 3'd7;

  typedef struct {
    logic            ok;
    logic [WordW-1:0] left;
    logic [WordW-1:0] right;
    status_e         status;
    logic [LvlW-1:0] level;
    logic [LvlW-1:0] free;
    just_e           just;
  } fifo_reply_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic [FuncW-1:0]   s_axis_tuser = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b1;
  logic [OutW-1:0]    m_axis_tdata;
  logic [0:0]         m_axis_tuser;

  // shadow of the ring buffer
  frame_t      frame_mem [Depth];
  bit          frame_written [Depth];
  int unsigned wr_idx = 0;
  int unsigned rd_idx = 0;
  int unsigned fill = 0;
  status_e     st_flag = ST_OK;
  just_e       just_mode = JM_UNKNOWN;

  fifo_reply_t fifo_reply_q[$];
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned replies_seen = 0;
  int unsigned cycles = 0;
  int unsigned ready_gap = 0;
  bit          calm = 1'b0;

  stereo_audio_frame_fifo dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void commit_frames(int unsigned n);
    if (n == 0) return;
    if (fill + n > Depth) begin
      // write pointer stays put, level pinned at full
      fill = Depth;
      st_flag = ST_OVFL;
    end else begin
      fill += n;
      wr_idx = (wr_idx + n) % Depth;
      st_flag = ST_OK;
    end
  endfunction

  function automatic logic [WordW-1:0] justify_word(logic [WordW-1:0] w);
    if (just_mode == JM_RIGHT) return w;
    return $unsigned($signed(w) >>> 8);
  endfunction

  function automatic fifo_reply_t step_fifo_model(logic [FuncW-1:0] fn, logic [OffsW-1:0] offs,
                                                  logic [WordW-1:0] lw, logic [WordW-1:0] rw,
                                                  logic [CommitW-1:0] n);
    fifo_reply_t r;
    int unsigned idx;
    logic [WordW-1:0] a, b;
    r.ok = 1'b0;
    r.left = '0;
    r.right = '0;
    case (fn)
      FN_STAGE: begin
        idx = (wr_idx + offs) % Depth;
        frame_mem[idx].left = lw;
        frame_mem[idx].right = rw;
        frame_written[idx] = 1'b1;
      end
      FN_COMMIT: commit_frames(n);
      FN_PUSH: begin
        if (fill >= Depth) begin
          st_flag = ST_OVFL;
        end else begin
          frame_mem[wr_idx].left = lw << 8;
          frame_mem[wr_idx].right = rw << 8;
          frame_written[wr_idx] = 1'b1;
          commit_frames(1);
          r.ok = 1'b1;
        end
      end
      FN_POP: begin
        if (fill < 1) begin
          fill = 0;
          st_flag = ST_UDFL;
        end else begin
          a = frame_mem[rd_idx].left;
          b = frame_mem[rd_idx].right;
          if (just_mode == JM_UNKNOWN)
            just_mode = (((a | b) & 32'hFF) == 0) ? JM_LEFT : JM_RIGHT;
          r.left = justify_word(a);
          r.right = justify_word(b);
          rd_idx = (rd_idx + 1) % Depth;
          fill -= 1;
          st_flag = ST_OK;
          r.ok = 1'b1;
        end
      end
      FN_CLEAR: begin
        wr_idx = 0;
        rd_idx = 0;
        fill = 0;
        st_flag = ST_OK;
      end
      default: ;
    endcase
    r.status = st_flag;
    r.level = LvlW'(fill);
    r.free = (fill >= Depth) ? '0 : LvlW'(Depth - fill);
    r.just = just_mode;
    return r;
  endfunction

  task automatic send_item(input logic [FuncW-1:0] fn, input logic [OffsW-1:0] offs,
                           input logic [WordW-1:0] lw, input logic [WordW-1:0] rw,
                           input logic [CommitW-1:0] n);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= fn;
    s_axis_tdata <= InDataW'({n, rw, lw, offs});
    do @(posedge clk_i); while (!s_axis_tready);
    fifo_reply_q.push_back(step_fifo_model(fn, offs, lw, rw, n));
    items_sent++;
  endtask

  // a pop must never land on a store entry that was never written
  task automatic send_pop();
    if (fill > 0 && !frame_written[rd_idx])
      send_item(FN_CLEAR, OffsW'($urandom()), $urandom(), $urandom(), CommitW'($urandom()));
    else
      send_item(FN_POP, OffsW'($urandom()), $urandom(), $urandom(), CommitW'($urandom()));
  endtask

  task automatic wait_all_replies();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (fifo_reply_q.size() != 0);
  endtask

  task automatic report_mismatch(string what);
    errors++;
    if (errors <= MaxReports) $display("mismatch at reply %0d: %s", replies_seen, what);
  endtask

  task automatic check_reply();
    fifo_reply_t want;
    logic [WordW-1:0] got_l, got_r;
    logic [1:0]       got_st, got_jm;
    logic [LvlW-1:0]  got_lvl, got_free;
    got_l    = m_axis_tdata[31:0];
    got_r    = m_axis_tdata[63:32];
    got_st   = m_axis_tdata[65:64];
    got_lvl  = m_axis_tdata[66 +: LvlW];
    got_free = m_axis_tdata[77 +: LvlW];
    got_jm   = m_axis_tdata[88 +: 2];
    if (fifo_reply_q.size() == 0) begin
      report_mismatch("result with nothing outstanding");
    end else begin
      want = fifo_reply_q.pop_front();
      if (m_axis_tuser[0] !== want.ok)
        report_mismatch($sformatf("ok %b, want %b", m_axis_tuser[0], want.ok));
      if (got_l !== want.left)
        report_mismatch($sformatf("left %h, want %h", got_l, want.left));
      if (got_r !== want.right)
        report_mismatch($sformatf("right %h, want %h", got_r, want.right));
      if (got_st !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got_st, want.status));
      if (got_lvl !== want.level)
        report_mismatch($sformatf("level %0d, want %0d", got_lvl, want.level));
      if (got_free !== want.free)
        report_mismatch($sformatf("free %0d, want %0d", got_free, want.free));
      if (got_jm !== want.just)
        report_mismatch($sformatf("justify %0d, want %0d", got_jm, want.just));
    end
    replies_seen++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_reply();
    if (ready_gap > 0) begin
      ready_gap--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      ready_gap = $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("stereo_audio_frame_fifo_test: done, errors");
      $finish;
    end
  end

  task automatic test_underflow_and_spare_codes();
    send_pop();
    send_item(FN_COMMIT, '0, '0, '0, '0);
    for (int f = FnSpareLo; f <= FnSpareHi; f++)
      send_item(FuncW'(f), OffsW'($urandom()), $urandom(), $urandom(), 9'h1FF);
  endtask

  // the first pop with data fixes the justification for the rest of the run
  task automatic test_justify_detect();
    logic [WordW-1:0] lw, rw;
    lw = $urandom();
    rw = $urandom();
    if ($urandom_range(0, 1)) begin
      lw[7:0] = '0;
      rw[7:0] = '0;
    end else begin
      lw[0] = 1'b1;
    end
    send_item(FN_STAGE, '0, lw, rw, '0);
    send_item(FN_COMMIT, '0, '0, '0, 9'd1);
    send_pop();
  endtask

  task automatic test_push_extremes();
    send_item(FN_PUSH, '0, 32'hFFFF_FFFF, 32'h0000_0000, '0);
    send_item(FN_PUSH, '0, 32'h0080_0000, 32'h007F_FFFF, '0);
    send_pop();
    send_pop();
  endtask

  task automatic test_wrap_and_overflow();
    send_item(FN_CLEAR, '0, '0, '0, '0);
    repeat (3) send_item(FN_COMMIT, '0, '0, '0, 9'd256);
    send_item(FN_COMMIT, '0, '0, '0, 9'd200);
    // write pointer near the top, so the largest offset wraps
    send_item(FN_STAGE, 8'hFF, 32'h8000_0000, 32'h7FFF_FFFF, '0);
    send_item(FN_PUSH, '0, $urandom(), $urandom(), '0);
    send_item(FN_COMMIT, '0, '0, '0, 9'd56);
    send_item(FN_PUSH, '0, $urandom(), $urandom(), '0);
    send_item(FN_COMMIT, '0, '0, '0, 9'd256);
    send_pop();
    send_item(FN_CLEAR, '0, '0, '0, '0);
  endtask

  task automatic send_packet();
    int unsigned n;
    bit down;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
    down = 1'($urandom_range(0, 1));
    for (int unsigned i = 0; i < n; i++)
      send_item(FN_STAGE, down ? OffsW'(n - 1 - i) : OffsW'(i), $urandom(), $urandom(),
                CommitW'($urandom()));
    send_item(FN_COMMIT, OffsW'($urandom()), $urandom(), $urandom(), CommitW'(n));
  endtask

  task automatic send_noise();
    logic [FuncW-1:0] fn;
    fn = FuncW'($urandom_range(0, 7));
    if (fn == FN_POP)
      send_pop();
    else
      send_item(fn, OffsW'($urandom()), $urandom(), $urandom(),
                CommitW'($urandom_range(0, 256)));
  endtask

  task automatic test_random_traffic();
    int unsigned target;
    int unsigned kind;
    bit paused;
    target = items_sent + RandomItems;
    paused = 1'b0;
    while (items_sent < target) begin
      if (target - items_sent < CalmItems) calm = 1'b1;
      kind = $urandom_range(0, 99);
      if (kind < 40)
        send_packet();
      else if (kind < 60)
        repeat ($urandom_range(1, 6))
          send_item(FN_PUSH, OffsW'($urandom()), $urandom(), $urandom(),
                    CommitW'($urandom()));
      else if (kind < 85)
        repeat ($urandom_range(1, 8)) send_pop();
      else
        send_noise();
      if (!paused && items_sent >= target - RandomItems / 2) begin
        wait_all_replies();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_underflow_and_spare_codes();
    test_justify_detect();
    test_push_extremes();
    test_wrap_and_overflow();
    wait_all_replies();
    test_random_traffic();
    wait_all_replies();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0)
      $display("stereo_audio_frame_fifo_test: done, clean");
    else
      $display("stereo_audio_frame_fifo_test: done, errors");
    $finish;
  end

endmodule
